// ===== rtl/core/tcch_pkg.sv =====
// Shared constants for the tilt-compensated compass heading pipeline.
package tcch_pkg;

    // Internal angle width, Q30 radians, holds +-1.5*pi with margin
    localparam int ZW = 35;
    // Fraction bits of internal angles
    localparam int ZFRAC = 30;
    // Left shift applied to samples on entry
    localparam int GUARD = 16;
    // Headroom bits above the scaled sample for CORDIC growth
    localparam int HEADROOM = 8;
    // Number of micro-rotation angles available
    localparam int TAB_LEN = 24;

    // CORDIC gain K in Q16
    localparam logic signed [17:0] GAIN_Q16 = 18'sd107922;

    localparam logic signed [ZW-1:0] HALF_PI_Q30   = 35'sd1686629713;
    localparam logic signed [ZW-1:0] PI_Q30        = 35'sd3373259426;
    localparam logic signed [ZW-1:0] THR_HALF_PI_Q30 = 35'sd5059889139;

    // atan(2^-i) in Q30, truncated
    localparam logic signed [ZW-1:0] ATAN_TAB [TAB_LEN] = '{
        35'sd843314856, 35'sd497837829, 35'sd263043836, 35'sd133525158,
        35'sd67021686,  35'sd33543515,  35'sd16775850,  35'sd8388437,
        35'sd4194282,   35'sd2097149,   35'sd1048575,   35'sd524287,
        35'sd262143,    35'sd131071,    35'sd65535,     35'sd32767,
        35'sd16383,     35'sd8191,      35'sd4095,      35'sd2047,
        35'sd1023,      35'sd511,       35'sd255,       35'sd127
    };

endpackage

// ===== rtl/core/tcch_cell.sv =====
// One CORDIC micro-rotation stage, registered, with side payload.
module tcch_cell #(
    parameter int IDX = 0,
    parameter bit VEC = 1'b1,
    parameter int W   = 40,
    parameter int PW  = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [W-1:0]           i_x,
    input  logic signed [W-1:0]           i_y,
    input  logic signed [tcch_pkg::ZW-1:0] i_z,
    input  logic [PW-1:0]                 i_pay,
    output logic                          o_valid,
    output logic signed [W-1:0]           o_x,
    output logic signed [W-1:0]           o_y,
    output logic signed [tcch_pkg::ZW-1:0] o_z,
    output logic [PW-1:0]                 o_pay
);

    logic signed [W-1:0] dx, dy;
    logic                dir_neg;
    logic signed [W-1:0] n_x, n_y;
    logic signed [tcch_pkg::ZW-1:0] n_z;

    assign dx = i_x >>> IDX;
    assign dy = i_y >>> IDX;

    // vectoring drives y toward zero, rotation drives z toward zero
    assign dir_neg = VEC ? i_y[W-1] : i_z[tcch_pkg::ZW-1];

    always_comb begin
        if (dir_neg) begin
            n_x = VEC ? (i_x - dy) : (i_x + dy);
            n_y = VEC ? (i_y + dx) : (i_y - dx);
            n_z = VEC ? (i_z - tcch_pkg::ATAN_TAB[IDX]) : (i_z + tcch_pkg::ATAN_TAB[IDX]);
        end else begin
            n_x = VEC ? (i_x + dy) : (i_x - dy);
            n_y = VEC ? (i_y - dx) : (i_y + dx);
            n_z = VEC ? (i_z + tcch_pkg::ATAN_TAB[IDX]) : (i_z - tcch_pkg::ATAN_TAB[IDX]);
        end
    end

    // data beat advances every cycle
    always_ff @(posedge i_clk) begin
        o_x   <= n_x;
        o_y   <= n_y;
        o_z   <= n_z;
        o_pay <= i_pay;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
    end

endmodule

// ===== rtl/core/tcch_row.sv =====
// CORDIC row: quadrant pre-rotation register followed by a chain of cells.
module tcch_row #(
    parameter bit VEC    = 1'b1,
    parameter int W      = 40,
    parameter int PW     = 1,
    parameter int STAGES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [W-1:0]           i_x,
    input  logic signed [W-1:0]           i_y,
    input  logic signed [tcch_pkg::ZW-1:0] i_z,
    input  logic [PW-1:0]                 i_pay,
    output logic                          o_valid,
    output logic signed [W-1:0]           o_x,
    output logic signed [W-1:0]           o_y,
    output logic signed [tcch_pkg::ZW-1:0] o_z,
    output logic [PW-1:0]                 o_pay
);

    logic signed [W-1:0] n_x, n_y;
    logic signed [tcch_pkg::ZW-1:0] n_z;
    logic                n_zero;

    logic                        v_s   [STAGES+1];
    logic signed [W-1:0]         x_s   [STAGES+1];
    logic signed [W-1:0]         y_s   [STAGES+1];
    logic signed [tcch_pkg::ZW-1:0] z_s [STAGES+1];
    logic [PW:0]                 p_s   [STAGES+1];

    logic r_valid;
    logic signed [W-1:0] r_x, r_y;
    logic signed [tcch_pkg::ZW-1:0] r_z;
    logic [PW:0] r_pay;

    // quadrant pre-rotation by +-pi/2
    always_comb begin
        n_x    = i_x;
        n_y    = i_y;
        n_z    = i_z;
        n_zero = VEC && (i_x == '0) && (i_y == '0);
        if (VEC) begin
            if (i_x[W-1]) begin
                if (!i_y[W-1]) begin
                    n_x = i_y;
                    n_y = -i_x;
                    n_z = i_z + tcch_pkg::HALF_PI_Q30;
                end else begin
                    n_x = -i_y;
                    n_y = i_x;
                    n_z = i_z - tcch_pkg::HALF_PI_Q30;
                end
            end
        end else begin
            if (i_z > tcch_pkg::HALF_PI_Q30) begin
                n_x = -i_y;
                n_y = i_x;
                n_z = i_z - tcch_pkg::HALF_PI_Q30;
            end else if (i_z < -tcch_pkg::HALF_PI_Q30) begin
                n_x = i_y;
                n_y = -i_x;
                n_z = i_z + tcch_pkg::HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_z   <= n_z;
        r_pay <= {n_zero, i_pay};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    assign v_s[0] = r_valid;
    assign x_s[0] = r_x;
    assign y_s[0] = r_y;
    assign z_s[0] = r_z;
    assign p_s[0] = r_pay;

    // chain of micro-rotation cells
    for (genvar k = 0; k < STAGES; k++) begin : g_cell
        tcch_cell #(
            .IDX (k),
            .VEC (VEC),
            .W   (W),
            .PW  (PW + 1)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v_s[k]),
            .i_x     (x_s[k]),
            .i_y     (y_s[k]),
            .i_z     (z_s[k]),
            .i_pay   (p_s[k]),
            .o_valid (v_s[k+1]),
            .o_x     (x_s[k+1]),
            .o_y     (y_s[k+1]),
            .o_z     (z_s[k+1]),
            .o_pay   (p_s[k+1])
        );
    end

    // zero vector gives angle 0 and magnitude 0
    assign o_valid = v_s[STAGES];
    assign o_x     = p_s[STAGES][PW] ? '0 : x_s[STAGES];
    assign o_y     = y_s[STAGES];
    assign o_z     = p_s[STAGES][PW] ? '0 : z_s[STAGES];
    assign o_pay   = p_s[STAGES][PW-1:0];

endmodule

// ===== rtl/core/tilt_compensated_compass_heading.sv =====
// Top level: tilt-compensated compass heading, fully pipelined CORDIC rows.
//
// One sample set is taken at every clock edge where start is high; busy
// stays low, so a new sample can enter every cycle. Each result appears on
// the output ports for one cycle with o_valid high. The path from sample to
// result is the depth of the four CORDIC rows (roll, pitch with the roll
// rotation beside it, pitch rotation, yaw), each a pre-rotation stage plus
// one stage per micro-rotation, and four register stages for entry, gain
// multiplies and the output. Results cannot be held off, so the receiver must
// take every o_valid beat. Angles are signed radians with ANGLE_FRAC_BITS
// fraction bits; heading is yaw minus pi/2 when accel_z is negative, else
// minus 1.5*pi.
module tilt_compensated_compass_heading #(
    parameter int SAMPLE_BITS     = 16,
    parameter int ANGLE_FRAC_BITS = 13,
    parameter int CORDIC_STAGES   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [SAMPLE_BITS-1:0]     i_accel_x,
    input  logic signed [SAMPLE_BITS-1:0]     i_accel_y,
    input  logic signed [SAMPLE_BITS-1:0]     i_accel_z,
    input  logic signed [SAMPLE_BITS-1:0]     i_mag_x,
    input  logic signed [SAMPLE_BITS-1:0]     i_mag_y,
    input  logic signed [SAMPLE_BITS-1:0]     i_mag_z,
    output logic                              o_valid,
    output logic signed [ANGLE_FRAC_BITS+2:0] o_roll_angle,
    output logic signed [ANGLE_FRAC_BITS+1:0] o_pitch_angle,
    output logic signed [ANGLE_FRAC_BITS+3:0] o_heading
);

    localparam int W   = SAMPLE_BITS + tcch_pkg::GUARD + tcch_pkg::HEADROOM;
    localparam int ZW  = tcch_pkg::ZW;
    localparam int SH  = tcch_pkg::ZFRAC - ANGLE_FRAC_BITS;
    localparam int LAT = 4 * CORDIC_STAGES + 8;
    localparam int EXT = W - SAMPLE_BITS - tcch_pkg::GUARD;
    localparam int PW1 = 4 * W + 1;
    localparam int PW2 = W + ZW;
    localparam int PW3 = W + 2 * ZW + 1;
    localparam int PW4 = 2 * ZW + 1;

    localparam logic signed [ZW-1:0] RND   = ZW'(64'sd1 <<< (SH - 1));
    localparam logic signed [ZW-1:0] PI_F  = (tcch_pkg::PI_Q30 + RND) >>> SH;
    localparam logic signed [ZW-1:0] HPI_F = (tcch_pkg::HALF_PI_Q30 + RND) >>> SH;
    localparam logic signed [ZW-1:0] TPI_F = (tcch_pkg::THR_HALF_PI_Q30 + RND) >>> SH;

    // multiply by K, rounded half up
    function automatic logic signed [W-1:0] f_gain(input logic signed [W-1:0] v);
        logic signed [W+17:0] p;
        p = (W+18)'(v) * (W+18)'(tcch_pkg::GAIN_Q16);
        p = p + (W+18)'(32768);
        return W'(p >>> 16);
    endfunction

    // round Q30 to output fraction and saturate
    function automatic logic signed [ZW-1:0] f_angle(input logic signed [ZW-1:0] q,
                                                     input logic signed [ZW-1:0] lim);
        logic signed [ZW-1:0] r;
        r = (q + RND) >>> SH;
        if (r > lim) begin
            r = lim;
        end else if (r < -lim) begin
            r = -lim;
        end
        return r;
    endfunction

    assign busy = 1'b0;

    // entry stage: scale samples
    logic r_a_v;
    logic signed [W-1:0] r_ax, r_ay, r_az, r_mx, r_my, r_mz;

    always_ff @(posedge i_clk) begin
        r_ax <= {{EXT{i_accel_x[SAMPLE_BITS-1]}}, i_accel_x, {tcch_pkg::GUARD{1'b0}}};
        r_ay <= {{EXT{i_accel_y[SAMPLE_BITS-1]}}, i_accel_y, {tcch_pkg::GUARD{1'b0}}};
        r_az <= {{EXT{i_accel_z[SAMPLE_BITS-1]}}, i_accel_z, {tcch_pkg::GUARD{1'b0}}};
        r_mx <= {{EXT{i_mag_x[SAMPLE_BITS-1]}}, i_mag_x, {tcch_pkg::GUARD{1'b0}}};
        r_my <= {{EXT{i_mag_y[SAMPLE_BITS-1]}}, i_mag_y, {tcch_pkg::GUARD{1'b0}}};
        r_mz <= {{EXT{i_mag_z[SAMPLE_BITS-1]}}, i_mag_z, {tcch_pkg::GUARD{1'b0}}};
    end

    // roll row: atan2(ay, az) and magnitude
    logic r1_v;
    logic signed [W-1:0] r1_x, r1_y;
    logic signed [ZW-1:0] r1_z;
    logic [PW1-1:0] r1_p;

    tcch_row #(.VEC(1'b1), .W(W), .PW(PW1), .STAGES(CORDIC_STAGES)) u_roll (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r_a_v),
        .i_x (r_az), .i_y (r_ay), .i_z ('0),
        .i_pay ({r_ax, r_mx, r_my, r_mz, r_az[W-1]}),
        .o_valid (r1_v), .o_x (r1_x), .o_y (r1_y), .o_z (r1_z), .o_pay (r1_p)
    );

    // gain stage for pitch and yaw inputs
    logic r_b_v, r_b_azn;
    logic signed [W-1:0] r_b_mag, r_b_gax, r_b_gmx, r_b_my, r_b_mz;
    logic signed [ZW-1:0] r_b_roll;

    always_ff @(posedge i_clk) begin
        r_b_mag  <= r1_x;
        r_b_gax  <= f_gain(-r1_p[4*W:3*W+1]);
        r_b_gmx  <= f_gain(r1_p[3*W:2*W+1]);
        r_b_my   <= r1_p[2*W:W+1];
        r_b_mz   <= r1_p[W:1];
        r_b_azn  <= r1_p[0];
        r_b_roll <= r1_z;
    end

    // pitch row beside the roll rotation of the magnetic vector
    logic r2a_v, r2b_v;
    logic signed [W-1:0] r2a_x, r2a_y, r2b_x, r2b_y;
    logic signed [ZW-1:0] r2a_z, r2b_z;
    logic [PW2-1:0] r2a_p;
    logic r2b_p;

    tcch_row #(.VEC(1'b1), .W(W), .PW(PW2), .STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r_b_v),
        .i_x (r_b_mag), .i_y (r_b_gax), .i_z ('0),
        .i_pay ({r_b_gmx, r_b_roll}),
        .o_valid (r2a_v), .o_x (r2a_x), .o_y (r2a_y), .o_z (r2a_z), .o_pay (r2a_p)
    );

    tcch_row #(.VEC(1'b0), .W(W), .PW(1), .STAGES(CORDIC_STAGES)) u_mrot (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r_b_v),
        .i_x (r_b_mz), .i_y (-r_b_my), .i_z (r_b_roll),
        .i_pay (r_b_azn),
        .o_valid (r2b_v), .o_x (r2b_x), .o_y (r2b_y), .o_z (r2b_z), .o_pay (r2b_p)
    );

    // gain on the yaw numerator
    logic r_c_v, r_c_azn;
    logic signed [W-1:0] r_c_bx, r_c_gmx, r_c_gby;
    logic signed [ZW-1:0] r_c_pitch, r_c_roll;

    always_ff @(posedge i_clk) begin
        r_c_bx    <= r2b_x;
        r_c_gby   <= f_gain(r2b_y);
        r_c_gmx   <= r2a_p[PW2-1:ZW];
        r_c_roll  <= r2a_p[ZW-1:0];
        r_c_pitch <= r2a_z;
        r_c_azn   <= r2b_p;
    end

    // pitch rotation: y gives the yaw denominator
    logic r3_v;
    logic signed [W-1:0] r3_x, r3_y;
    logic signed [ZW-1:0] r3_z;
    logic [PW3-1:0] r3_p;

    tcch_row #(.VEC(1'b0), .W(W), .PW(PW3), .STAGES(CORDIC_STAGES)) u_prot (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r_c_v),
        .i_x (r_c_bx), .i_y (r_c_gmx), .i_z (r_c_pitch),
        .i_pay ({r_c_gby, r_c_pitch, r_c_roll, r_c_azn}),
        .o_valid (r3_v), .o_x (r3_x), .o_y (r3_y), .o_z (r3_z), .o_pay (r3_p)
    );

    // yaw row
    logic r4_v;
    logic signed [W-1:0] r4_x, r4_y;
    logic signed [ZW-1:0] r4_z;
    logic [PW4-1:0] r4_p;

    tcch_row #(.VEC(1'b1), .W(W), .PW(PW4), .STAGES(CORDIC_STAGES)) u_yaw (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r3_v),
        .i_x (r3_y), .i_y (r3_p[PW3-1:PW4]), .i_z ('0),
        .i_pay (r3_p[PW4-1:0]),
        .o_valid (r4_v), .o_x (r4_x), .o_y (r4_y), .o_z (r4_z), .o_pay (r4_p)
    );

    // output stage: round, saturate, apply bearing offset
    logic signed [ZW-1:0] n_roll, n_pitch, n_yaw, n_head;

    always_comb begin
        n_pitch = f_angle(r4_p[PW4-1:ZW+1], HPI_F);
        n_roll  = f_angle(r4_p[ZW:1], PI_F);
        n_yaw   = f_angle(r4_z, PI_F);
        n_head  = n_yaw - (r4_p[0] ? HPI_F : TPI_F);
    end

    always_ff @(posedge i_clk) begin
        o_roll_angle  <= n_roll[ANGLE_FRAC_BITS+2:0];
        o_pitch_angle <= n_pitch[ANGLE_FRAC_BITS+1:0];
        o_heading     <= n_head[ANGLE_FRAC_BITS+3:0];
    end

    // valid flags of the register stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_c_v   <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_a_v   <= start;
            r_b_v   <= r1_v;
            r_c_v   <= r2a_v;
            o_valid <= r4_v;
        end
    end

    // the two middle rows must stay in step
    a_rows_aligned : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2a_v == r2b_v)
        else $error("pitch row and rotation row out of step");

    // every result beat matches a sample beat a fixed latency earlier
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n, LAT) |-> (o_valid == $past(start, LAT)))
        else $error("result beat without matching sample beat");

    // saturated angles stay in range
    a_roll_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((ZW'(o_roll_angle) <= PI_F) && (ZW'(o_roll_angle) >= -PI_F)))
        else $error("roll out of range");

    a_pitch_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((ZW'(o_pitch_angle) <= HPI_F) && (ZW'(o_pitch_angle) >= -HPI_F)))
        else $error("pitch out of range");

endmodule

// ===== test/tilt_compensated_compass_heading_tb.sv =====
// Testbench for the tilt-compensated compass heading pipeline.
`timescale 1ns / 100ps

module tilt_compensated_compass_heading_tb;

    localparam longint HPI_Q30   = 64'sd1686629713;
    localparam longint PI_Q30    = 64'sd3373259426;
    localparam longint THPI_Q30  = 64'sd5059889139;
    localparam int     STAGES    = 16;
    localparam int     FRAC      = 13;
    localparam int     LATENCY   = 4 * STAGES + 8;

    localparam longint ROT_ANGLE [24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191,
        4095, 2047, 1023, 511, 255, 127
    };

    typedef struct packed {
        logic signed [15:0] ax, ay, az, mx, my, mz;
    } sensor_beat_t;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [16:0] head;
    } attitude_t;

    typedef struct {
        sensor_beat_t s;
        bit           typed;
        attitude_t    want;
    } table_row_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] i_accel_x, i_accel_y, i_accel_z;
    logic signed [15:0] i_mag_x, i_mag_y, i_mag_z;
    logic               o_valid;
    logic signed [15:0] o_roll_angle;
    logic signed [14:0] o_pitch_angle;
    logic signed [16:0] o_heading;

    attitude_t   pending_angles[$];
    int          err_cnt;
    table_row_t  rows[$];

    tilt_compensated_compass_heading dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_accel_x(i_accel_x), .i_accel_y(i_accel_y), .i_accel_z(i_accel_z),
        .i_mag_x(i_mag_x), .i_mag_y(i_mag_y), .i_mag_z(i_mag_z),
        .o_valid(o_valid), .o_roll_angle(o_roll_angle),
        .o_pitch_angle(o_pitch_angle), .o_heading(o_heading)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ---------------- angle predictor ----------------
    function automatic longint scaled(logic signed [15:0] v);
        longint r;
        r = longint'(v);
        return r * 65536;
    endfunction

    function automatic longint q30_to_out(longint q);
        return (q + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
    endfunction

    function automatic longint sat(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint apply_gain(longint v);
        return (v * 107922 + 64'sd32768) >>> 16;
    endfunction

    function automatic longint cordic_atan2(longint x, longint y, output longint mag);
        longint z, t, dx, dy;
        z = 0;
        mag = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = HPI_Q30;
            end else begin
                x = -y; y = t; z = -HPI_Q30;
            end
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (y < 0) begin
                x -= dy; y += dx; z -= ROT_ANGLE[i];
            end else begin
                x += dy; y -= dx; z += ROT_ANGLE[i];
            end
        end
        mag = x;
        return z;
    endfunction

    function automatic void cordic_rotate(inout longint x, inout longint y, input longint z);
        longint t, dx, dy;
        if (z > HPI_Q30) begin
            t = x; x = -y; y = t; z -= HPI_Q30;
        end else if (z < -HPI_Q30) begin
            t = x; x = y; y = -t; z += HPI_Q30;
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (z >= 0) begin
                x -= dy; y += dx; z -= ROT_ANGLE[i];
            end else begin
                x += dy; y -= dx; z += ROT_ANGLE[i];
            end
        end
    endfunction

    function automatic attitude_t predict_attitude(sensor_beat_t s);
        longint ax, ay, az, mx, my, mz, rmag, dummy;
        longint roll_q, pitch_q, yaw_q, bx, by, cx, cy, yaw, hd;
        attitude_t a;
        ax = scaled(s.ax); ay = scaled(s.ay); az = scaled(s.az);
        mx = scaled(s.mx); my = scaled(s.my); mz = scaled(s.mz);
        roll_q  = cordic_atan2(az, ay, rmag);
        pitch_q = cordic_atan2(rmag, apply_gain(-ax), dummy);
        bx = mz;
        by = -my;
        cordic_rotate(bx, by, roll_q);
        cx = bx;
        cy = apply_gain(mx);
        cordic_rotate(cx, cy, pitch_q);
        yaw_q = cordic_atan2(cy, apply_gain(by), dummy);
        a.roll  = 16'(sat(q30_to_out(roll_q), q30_to_out(PI_Q30)));
        a.pitch = 15'(sat(q30_to_out(pitch_q), q30_to_out(HPI_Q30)));
        yaw = sat(q30_to_out(yaw_q), q30_to_out(PI_Q30));
        // bearing offset: zero az counts as not negative
        hd = yaw - ((s.az < 0) ? q30_to_out(HPI_Q30) : q30_to_out(THPI_Q30));
        a.head = 17'(hd);
        return a;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic logic signed [15:0] pick_axis();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sd0;
            3, 4: return 16'($urandom_range(0, 64) - 32);
            default: return 16'($urandom());
        endcase
    endfunction

    // drive one beat, hold it until taken, queue its expected angles
    task automatic push_beat(sensor_beat_t s, bit typed, attitude_t want);
        bit taken;
        start     <= 1'b1;
        i_accel_x <= s.ax; i_accel_y <= s.ay; i_accel_z <= s.az;
        i_mag_x   <= s.mx; i_mag_y   <= s.my; i_mag_z   <= s.mz;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end
        pending_angles.push_back(typed ? want : predict_attitude(s));
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic sensor_beat_t mk(int ax, int ay, int az, int mx, int my, int mz);
        sensor_beat_t s;
        s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az);
        s.mx = 16'(mx); s.my = 16'(my); s.mz = 16'(mz);
        return s;
    endfunction

    task automatic add_row(sensor_beat_t s);
        table_row_t r;
        r.s = s; r.typed = 1'b0; r.want = '0;
        rows.push_back(r);
    endtask

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        attitude_t w;
        if (i_rst_n && o_valid) begin
            if (pending_angles.size() == 0) begin
                $display("%0t: unexpected beat roll=%0d pitch=%0d heading=%0d",
                         $realtime, o_roll_angle, o_pitch_angle, o_heading);
                err_cnt++;
            end else begin
                w = pending_angles.pop_front();
                if (o_roll_angle !== w.roll) begin
                    $display("%0t: roll expected %0d actual %0d",
                             $realtime, w.roll, o_roll_angle);
                    err_cnt++;
                end
                if (o_pitch_angle !== w.pitch) begin
                    $display("%0t: pitch expected %0d actual %0d",
                             $realtime, w.pitch, o_pitch_angle);
                    err_cnt++;
                end
                if (o_heading !== w.head) begin
                    $display("%0t: heading expected %0d actual %0d",
                             $realtime, w.head, o_heading);
                    err_cnt++;
                end
            end
        end
    end

    // run limit
    initial begin
        #60000000;
        $display("TEST FAILED");
        $finish;
    end

    // ---------------- main sequence ----------------
    initial begin
        table_row_t r;
        sensor_beat_t s;
        int n_rand, wait_cnt;
        err_cnt   = 0;
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_accel_x = '0; i_accel_y = '0; i_accel_z = '0;
        i_mag_x   = '0; i_mag_y   = '0; i_mag_z   = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero vector: every angle 0, offset 1.5*pi since az is not negative
        r.s = mk(0, 0, 0, 0, 0, 0);
        r.typed = 1'b1;
        r.want.roll = 16'sd0; r.want.pitch = 15'sd0; r.want.head = -17'sd38604;
        rows.push_back(r);
        add_row(mk(32767, 32767, 32767, 32767, 32767, 32767));
        add_row(mk(-32768, -32768, -32768, -32768, -32768, -32768));
        add_row(mk(1000, 0, 0, 500, 200, -300));      // vertical gravity, +x
        add_row(mk(-1000, 0, 0, 500, 200, -300));     // vertical gravity, -x
        add_row(mk(32767, 0, 0, 0, 0, 0));
        add_row(mk(-32768, 0, 0, 0, 0, 0));
        add_row(mk(0, 0, -16384, 1200, -800, 300));   // az negative
        add_row(mk(0, 0, 16384, 1200, -800, 300));
        add_row(mk(0, 16384, 0, 1200, -800, 300));    // az zero
        add_row(mk(0, -16384, 0, -1200, 800, 300));
        add_row(mk(0, 0, 16384, 0, 0, 0));            // yaw terms zero
        add_row(mk(-32768, 32767, -32768, 32767, -32768, 32767));
        add_row(mk(32767, -32768, 32767, -32768, 32767, -32768));
        add_row(mk(0, -1, -1, 1, 0, 0));
        add_row(mk(5, -7, -9, 32767, 0, -32768));
        foreach (rows[k]) begin
            push_beat(rows[k].s, rows[k].typed, rows[k].want);
            if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 13));
        end

        n_rand = 1150;
        for (int k = 0; k < n_rand; k++) begin
            s.ax = pick_axis(); s.ay = pick_axis(); s.az = pick_axis();
            s.mx = pick_axis(); s.my = pick_axis(); s.mz = pick_axis();
            push_beat(s, 1'b0, '0);
            // sender pauses until the pipeline has drained
            if (k == n_rand / 2) begin
                start <= 1'b0;
                while (pending_angles.size() != 0) @(posedge i_clk);
            end else if (k < n_rand - 150 && (k % 40) >= 20
                         && $urandom_range(0, 2) == 0) begin
                idle_cycles($urandom_range(1, 13));
            end
        end
        start <= 1'b0;

        wait_cnt = 0;
        while (pending_angles.size() != 0 && wait_cnt < 10 * LATENCY) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (LATENCY + 8) @(posedge i_clk);
        if (err_cnt == 0 && pending_angles.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
